>>> sv/lbc_pkg.sv
// Shared types and constants for the LRU block cache.
// Used by lbc_scan and lru_block_cache; depends on nothing else.
package lbc_pkg;

    // Default geometry, handed down as module parameter defaults.
    localparam int ENTRIES_DEF = 64;
    localparam int WORDS_DEF   = 16;

    // Fixed field widths.
    localparam int KEY_W   = 64;
    localparam int WORD_W  = 64;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 7;

    // Slot count register value after reset, clamped to ENTRIES.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Request command codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_MISS     = 2'd1,
        KIND_PUT_DONE = 2'd2
    } kind_t;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_GET_RD,
        ST_GET_LD,
        ST_RESP
    } state_t;

    // One entry of the tag memory.
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   node;
        logic [KEY_W-1:0]   block;
        logic [STAMP_W-1:0] stamp;
    } tag_t;

    // Outcome of a tag search.
    typedef struct packed {
        logic done;
        logic hit;
    } scan_res_t;

endpackage

>>> sv/lbc_scan.sv
// Tag search sequencer: walks the enabled slots through the tag memory read port
// and picks a hit, the lowest empty slot or the oldest slot. Depends on lbc_pkg.
module lbc_scan
    import lbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key_node,
    input  logic [KEY_W-1:0] key_block,
    input  logic [IW-1:0]    n_last,
    input  tag_t             rd_data,
    output logic             rd_en,
    output logic [IW-1:0]    rd_addr,
    output scan_res_t        res,
    output logic [IW-1:0]    slot
);

    logic               active_reg, active_next;
    logic [IW-1:0]      issue_reg, issue_next;
    logic               issue_done_reg, issue_done_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               empty_found_reg, empty_found_next;
    logic [IW-1:0]      empty_idx_reg, empty_idx_next;
    logic [IW-1:0]      oldest_idx_reg, oldest_idx_next;
    logic [STAMP_W-1:0] oldest_stamp_reg, oldest_stamp_next;

    logic hit_now;
    logic empty_now;
    logic older_now;

    // Compare stage: the tag read last cycle is checked against the key.
    always_comb
    begin
        hit_now   = cmp_valid_reg && rd_data.valid &&
                    (rd_data.node == key_node) && (rd_data.block == key_block);
        empty_now = cmp_valid_reg && !rd_data.valid;
        older_now = cmp_valid_reg &&
                    ((cmp_idx_reg == '0) || (rd_data.stamp < oldest_stamp_reg));

        res.done = active_reg && cmp_valid_reg && (hit_now || (cmp_idx_reg == n_last));
        res.hit  = hit_now;

        // A key match wins, then the lowest empty slot, then the oldest stamp.
        if (hit_now)
        begin
            slot = cmp_idx_reg;
        end
        else if (empty_found_reg)
        begin
            slot = empty_idx_reg;
        end
        else if (empty_now || older_now)
        begin
            slot = cmp_idx_reg;
        end
        else
        begin
            slot = oldest_idx_reg;
        end

        rd_en   = active_reg && !issue_done_reg;
        rd_addr = issue_reg;
    end

    // Issue counter and running records.
    always_comb
    begin
        active_next       = active_reg;
        issue_next        = issue_reg;
        issue_done_next   = issue_done_reg;
        cmp_valid_next    = cmp_valid_reg;
        cmp_idx_next      = cmp_idx_reg;
        empty_found_next  = empty_found_reg;
        empty_idx_next    = empty_idx_reg;
        oldest_idx_next   = oldest_idx_reg;
        oldest_stamp_next = oldest_stamp_reg;

        if (start)
        begin
            active_next      = 1'b1;
            issue_next       = '0;
            issue_done_next  = 1'b0;
            cmp_valid_next   = 1'b0;
            empty_found_next = 1'b0;
        end
        else if (active_reg)
        begin
            cmp_valid_next = rd_en;
            cmp_idx_next   = issue_reg;
            if (rd_en)
            begin
                issue_next = issue_reg + IW'(1);
                if (issue_reg == n_last)
                begin
                    issue_done_next = 1'b1;
                end
            end
            if (empty_now && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_idx_next   = cmp_idx_reg;
            end
            if (older_now)
            begin
                oldest_idx_next   = cmp_idx_reg;
                oldest_stamp_next = rd_data.stamp;
            end
            if (res.done)
            begin
                active_next    = 1'b0;
                cmp_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            issue_reg       <= '0;
            issue_done_reg  <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            issue_reg       <= issue_next;
            issue_done_reg  <= issue_done_next;
            cmp_valid_reg   <= cmp_valid_next;
            empty_found_reg <= empty_found_next;
        end
    end

    // Record payloads carry no reset.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg      <= cmp_idx_next;
        empty_idx_reg    <= empty_idx_next;
        oldest_idx_reg   <= oldest_idx_next;
        oldest_stamp_reg <= oldest_stamp_next;
    end

    // The chosen slot always lies among the enabled slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.done |-> (slot <= n_last))
        else $error("scan chose a slot beyond the enabled range");

    // The compare stage only runs while a search is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> active_reg)
        else $error("tag compare outside an active search");

    // A key match always ends the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |-> res.done)
        else $error("tag match did not end the search");

endmodule

>>> sv/lru_block_cache.sv
// Fully associative block cache with LRU replacement: tag memory, block data
// memory and the transaction sequencer. Depends on lbc_pkg and lbc_scan.
//
// A get or the first word of a put searches the tag memory one slot per cycle
// through its single read port and stops early when the key matches. A get
// hit then refreshes its stamp and streams its block at one word per cycle
// while the result output is not stalled, as the data memory read port allows.
// Later words of a put are stored straight from the request, with no search.
// After reset a clearing pass runs over every tag memory slot; no transaction
// is accepted until it ends, but configuration writes are taken throughout.
module lru_block_cache
    import lbc_pkg::*;
#(
    parameter int ENTRIES         = ENTRIES_DEF,
    parameter int WORDS_PER_BLOCK = WORDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              command,
    input  logic [KEY_W-1:0]  node_id,
    input  logic [KEY_W-1:0]  block_id,
    input  logic [WORD_W-1:0] write_word,
    input  logic              write_last,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [1:0]        result_kind,
    output logic [WORD_W-1:0] read_word,
    output logic              read_last
);

    localparam int IW     = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int WCW    = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int DEPTH  = ENTRIES * WORDS_PER_BLOCK;
    localparam int AW     = $clog2(DEPTH);
    localparam int EN_RST = (int'(CFG_RESET) > ENTRIES) ? ENTRIES : int'(CFG_RESET);

    // Flat data address of one word of one slot.
    function automatic logic [AW-1:0] word_addr(input logic [IW-1:0] s,
                                                input logic [WCW-1:0] w);
        return AW'(s) * AW'(WORDS_PER_BLOCK) + AW'(w);
    endfunction

    state_t              state_reg, state_next;
    logic [CW-1:0]       enabled_reg, enabled_next;
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic [IW-1:0]       put_slot_reg, put_slot_next;
    logic [WCW-1:0]      put_count_reg, put_count_next;
    logic [IW-1:0]       clr_idx_reg, clr_idx_next;
    logic [IW-1:0]       get_slot_reg, get_slot_next;
    logic [WCW-1:0]      word_idx_reg, word_idx_next;
    kind_t               resp_kind_reg, resp_kind_next;

    logic                cmd_reg;
    logic [KEY_W-1:0]    node_reg;
    logic [KEY_W-1:0]    block_reg;
    logic [WORD_W-1:0]   wword_reg;
    logic                wlast_reg;

    logic                rsp_valid_reg, rsp_valid_next;
    kind_t               rsp_kind_reg, rsp_kind_next;
    logic [WORD_W-1:0]   rsp_word_reg, rsp_word_next;
    logic                rsp_last_reg, rsp_last_next;

    tag_t                tag_mem [ENTRIES];
    tag_t                tag_rdata_reg;
    logic                tag_we;
    logic [IW-1:0]       tag_waddr;
    tag_t                tag_wdata;

    logic [WORD_W-1:0]   data_mem [DEPTH];
    logic [WORD_W-1:0]   data_rdata_reg;
    logic                data_we;
    logic [AW-1:0]       data_waddr;
    logic [WORD_W-1:0]   data_wdata;
    logic                data_re;
    logic [AW-1:0]       data_raddr;

    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                scan_start;
    logic                scan_rd_en;
    logic [IW-1:0]       scan_rd_addr;
    scan_res_t           scan_res;
    logic [IW-1:0]       scan_slot;
    logic [IW-1:0]       n_last;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign n_last    = IW'(enabled_reg - CW'(1));

    // Enabled slot count, clamped to 1..ENTRIES when written.
    always_comb
    begin
        enabled_next = enabled_reg;
        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                enabled_next = CW'(1);
            end
            else if (32'(cfg_data) > 32'(ENTRIES))
            begin
                enabled_next = CW'(ENTRIES);
            end
            else
            begin
                enabled_next = CW'(cfg_data);
            end
        end
    end

    // Tag search unit.
    lbc_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .key_node  (node_reg),
        .key_block (block_reg),
        .n_last    (n_last),
        .rd_data   (tag_rdata_reg),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .res       (scan_res),
        .slot      (scan_slot)
    );

    // Sequencer: next state, memory accesses and result loading.
    always_comb
    begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        put_slot_next  = put_slot_reg;
        put_count_next = put_count_reg;
        clr_idx_next   = clr_idx_reg;
        get_slot_next  = get_slot_reg;
        word_idx_next  = word_idx_reg;
        resp_kind_next = resp_kind_reg;

        tag_we     = 1'b0;
        tag_waddr  = scan_slot;
        tag_wdata  = '{valid: 1'b1, node: node_reg, block: block_reg, stamp: clock_reg};
        data_we    = 1'b0;
        data_waddr = word_addr(put_slot_reg, put_count_reg);
        data_wdata = write_word;
        data_re    = 1'b0;
        data_raddr = word_addr(get_slot_reg, word_idx_reg);
        scan_start = 1'b0;

        out_load      = 1'b0;
        rsp_kind_next = rsp_kind_reg;
        rsp_word_next = rsp_word_reg;
        rsp_last_next = rsp_last_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                tag_we       = 1'b1;
                tag_waddr    = clr_idx_reg;
                tag_wdata    = '0;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == IW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((command == CMD_GET) || (put_count_reg == '0))
                    begin
                        scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        // Continuing put: store the word straight from the request.
                        data_we = 1'b1;
                        if (write_last || (put_count_reg == WCW'(WORDS_PER_BLOCK - 1)))
                        begin
                            put_count_next = '0;
                            resp_kind_next = KIND_PUT_DONE;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            put_count_next = put_count_reg + WCW'(1);
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    if (cmd_reg == CMD_GET)
                    begin
                        if (scan_res.hit)
                        begin
                            // Refresh the stamp, then stream the block.
                            tag_we        = 1'b1;
                            clock_next    = clock_reg + 32'd1;
                            get_slot_next = scan_slot;
                            word_idx_next = '0;
                            state_next    = ST_GET_RD;
                        end
                        else
                        begin
                            resp_kind_next = KIND_MISS;
                            state_next     = ST_RESP;
                        end
                    end
                    else
                    begin
                        // First put word claims the slot and fills word zero.
                        tag_we        = 1'b1;
                        clock_next    = clock_reg + 32'd1;
                        put_slot_next = scan_slot;
                        data_we       = 1'b1;
                        data_waddr    = word_addr(scan_slot, '0);
                        data_wdata    = wword_reg;
                        if (wlast_reg || (WORDS_PER_BLOCK == 1))
                        begin
                            put_count_next = '0;
                            resp_kind_next = KIND_PUT_DONE;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            put_count_next = WCW'(1);
                            state_next     = ST_IDLE;
                        end
                    end
                end
            end

            ST_GET_RD:
            begin
                data_re    = 1'b1;
                state_next = ST_GET_LD;
            end

            ST_GET_LD:
            begin
                // The read data holds until the output register can take it.
                if (out_free)
                begin
                    out_load      = 1'b1;
                    rsp_kind_next = KIND_HIT;
                    rsp_word_next = data_rdata_reg;
                    rsp_last_next = (word_idx_reg == WCW'(WORDS_PER_BLOCK - 1));
                    if (word_idx_reg == WCW'(WORDS_PER_BLOCK - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_idx_next = word_idx_reg + WCW'(1);
                        data_re       = 1'b1;
                        data_raddr    = word_addr(get_slot_reg, word_idx_reg + WCW'(1));
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    rsp_kind_next = resp_kind_reg;
                    rsp_word_next = '0;
                    rsp_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            enabled_reg   <= CW'(EN_RST);
            clock_reg     <= '0;
            put_slot_reg  <= '0;
            put_count_reg <= '0;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            enabled_reg   <= enabled_next;
            clock_reg     <= clock_next;
            put_slot_reg  <= put_slot_next;
            put_count_reg <= put_count_next;
            clr_idx_reg   <= clr_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            node_reg  <= node_id;
            block_reg <= block_id;
            wword_reg <= write_word;
            wlast_reg <= write_last;
        end
        get_slot_reg  <= get_slot_next;
        word_idx_reg  <= word_idx_next;
        resp_kind_reg <= resp_kind_next;
        rsp_kind_reg  <= rsp_kind_next;
        rsp_word_reg  <= rsp_word_next;
        rsp_last_reg  <= rsp_last_next;
    end

    // Tag memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (scan_rd_en)
        begin
            tag_rdata_reg <= tag_mem[scan_rd_addr];
        end
    end

    // Block data memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (data_re)
        begin
            data_rdata_reg <= data_mem[data_raddr];
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result_kind = rsp_kind_reg;
    assign read_word   = rsp_word_reg;
    assign read_last   = rsp_last_reg;

    // A finished search that updates a slot advances the access clock by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_res.done && (scan_res.hit || cmd_reg == CMD_PUT))
        |=> (clock_reg == $past(clock_reg) + 32'd1))
        else $error("access clock did not advance on a slot update");

    // The data memory is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(data_re && data_we))
        else $error("data memory read and write overlap");

    // Miss and put-done results are always single and marked last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_kind_reg != KIND_HIT) |-> rsp_last_reg)
        else $error("single result not marked last");

endmodule
